### hw/rtl/pst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime sieve table package
// Shared sizes, function codes and the table write bundle for the sieve
// engine and the core top level.
// ----------------------------------------------------------------------------
package pst_pkg;

   // Storage sizes
   localparam int MAP_DEPTH   = 65536;
   localparam int TABLE_DEPTH = 8192;

   // Field widths
   localparam int LIM_W = 16;
   localparam int VAL_W = 16;
   localparam int IDX_W = 13;
   localparam int CNT_W = $clog2(TABLE_DEPTH) + 1;

   // Address widths
   localparam int MAP_AW = $clog2(MAP_DEPTH);
   localparam int TBL_AW = $clog2(TABLE_DEPTH);

   // Sieve datapath width: holds any map index plus one step past the limit
   localparam int SV_W = (MAP_AW + 1 > LIM_W + 1) ? MAP_AW + 1 : LIM_W + 1;

   // Register reset value
   localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(20000);

   // Request function codes
   typedef enum logic {
      FUNC_BUILD = 1'b0,
      FUNC_READ  = 1'b1
   } func_type;

   // Prime table write bundle from the engine
   typedef struct packed {
      logic              en;
      logic [TBL_AW-1:0] addr;
      logic [VAL_W-1:0]  data;
   } tbl_wr_type;

endpackage

### hw/rtl/pst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data. The read
// data holds while the read enable is low.
// ----------------------------------------------------------------------------
module pst_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/pst_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime sieve build engine
// Sequencer around one shared adder and one limit comparator. Clears the
// composite map, marks multiples of each unmarked root, then scans the map
// and writes the primes into the prime table.
// ----------------------------------------------------------------------------
module pst_engine (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pst_pkg::LIM_W-1:0]  limit,
   output logic                       done,
   output logic [pst_pkg::CNT_W-1:0]  count,
   output pst_pkg::tbl_wr_type        tbl_wr
);

   localparam int SV_W   = pst_pkg::SV_W;
   localparam int MAP_AW = pst_pkg::MAP_AW;
   localparam int CNT_W  = pst_pkg::CNT_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLR,
      ST_MARK0,
      ST_MARK1,
      ST_SV_TEST,
      ST_SV_CHK,
      ST_SV_MARK,
      ST_SV_SQ,
      ST_SV_INC,
      ST_SC_RD,
      ST_SC_CHK
   } state_type;

   state_type          state_ff, state_in;
   logic [SV_W-1:0]    lim_ff, lim_in;
   logic [SV_W-1:0]    addr_ff, addr_in;
   logic [SV_W-1:0]    root_ff, root_in;
   logic [SV_W-1:0]    sq_ff, sq_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               done_ff, done_in;

   logic [SV_W-1:0]    lim_ext;
   logic [SV_W-1:0]    opa, opb, sum;
   logic [SV_W-1:0]    cmp_val;
   logic               over;

   logic               map_wr_en;
   logic [MAP_AW-1:0]  map_wr_addr;
   logic               map_wr_data;
   logic               map_rd_en;
   logic [MAP_AW-1:0]  map_rd_addr;
   logic               map_rd_data;

   // Clamp the limit to the last map entry
   always_comb begin
      lim_ext = SV_W'(limit);
      if (lim_ext > SV_W'(pst_pkg::MAP_DEPTH - 1)) begin
         lim_ext = SV_W'(pst_pkg::MAP_DEPTH - 1);
      end
   end

   // Shared adder operand select
   always_comb begin
      opa = addr_ff;
      opb = SV_W'(1);
      case (state_ff)
         ST_SV_MARK: begin
            opb = root_ff;
         end
         ST_SV_SQ: begin
            opa = sq_ff;
            opb = {root_ff[SV_W-2:0], 1'b1};
         end
         ST_SV_INC: begin
            opa = root_ff;
         end
         default: begin
            opa = addr_ff;
         end
      endcase
   end

   assign sum = opa + opb;

   // Shared limit comparator
   always_comb begin
      case (state_ff)
         ST_CLR:     cmp_val = sum;
         ST_SV_TEST: cmp_val = sq_ff;
         default:    cmp_val = addr_ff;
      endcase
   end

   assign over = cmp_val > lim_ff;

   // Sequencer next state and map / table access
   always_comb begin
      state_in    = state_ff;
      lim_in      = lim_ff;
      addr_in     = addr_ff;
      root_in     = root_ff;
      sq_in       = sq_ff;
      count_in    = count_ff;
      done_in     = 1'b0;
      map_wr_en   = 1'b0;
      map_wr_addr = addr_ff[MAP_AW-1:0];
      map_wr_data = 1'b0;
      map_rd_en   = 1'b0;
      map_rd_addr = addr_ff[MAP_AW-1:0];
      tbl_wr.en   = 1'b0;
      tbl_wr.addr = count_ff[pst_pkg::TBL_AW-1:0];
      tbl_wr.data = addr_ff[pst_pkg::VAL_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               lim_in   = lim_ext;
               addr_in  = '0;
               state_in = ST_CLR;
            end
         end
         // Clear the map up to the limit
         ST_CLR: begin
            map_wr_en = 1'b1;
            if (over) begin
               state_in = ST_MARK0;
            end else begin
               addr_in = sum;
            end
         end
         // Mark 0 and 1 as composite
         ST_MARK0: begin
            map_wr_en   = 1'b1;
            map_wr_addr = '0;
            map_wr_data = 1'b1;
            state_in    = ST_MARK1;
         end
         ST_MARK1: begin
            map_wr_en   = 1'b1;
            map_wr_addr = MAP_AW'(1);
            map_wr_data = 1'b1;
            root_in     = SV_W'(2);
            sq_in       = SV_W'(4);
            state_in    = ST_SV_TEST;
         end
         // Stop sieving once the square passes the limit
         ST_SV_TEST: begin
            if (over) begin
               addr_in  = SV_W'(2);
               count_in = '0;
               state_in = ST_SC_RD;
            end else begin
               map_rd_en   = 1'b1;
               map_rd_addr = root_ff[MAP_AW-1:0];
               state_in    = ST_SV_CHK;
            end
         end
         ST_SV_CHK: begin
            if (!map_rd_data) begin
               addr_in  = sq_ff;
               state_in = ST_SV_MARK;
            end else begin
               state_in = ST_SV_SQ;
            end
         end
         // Mark multiples starting at the square
         ST_SV_MARK: begin
            if (over) begin
               state_in = ST_SV_SQ;
            end else begin
               map_wr_en   = 1'b1;
               map_wr_data = 1'b1;
               addr_in     = sum;
            end
         end
         // Advance the square: (i+1)^2 = i^2 + 2i + 1
         ST_SV_SQ: begin
            sq_in    = sum;
            state_in = ST_SV_INC;
         end
         ST_SV_INC: begin
            root_in  = sum;
            state_in = ST_SV_TEST;
         end
         // Scan the map and collect primes
         ST_SC_RD: begin
            if (over) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               map_rd_en = 1'b1;
               state_in  = ST_SC_CHK;
            end
         end
         ST_SC_CHK: begin
            if (!map_rd_data && (count_ff < CNT_W'(pst_pkg::TABLE_DEPTH))) begin
               tbl_wr.en = 1'b1;
               count_in  = count_ff + CNT_W'(1);
            end
            addr_in  = sum;
            state_in = ST_SC_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      lim_ff  <= lim_in;
      addr_ff <= addr_in;
      root_ff <= root_in;
      sq_ff   <= sq_in;
   end

   pst_ram #(
      .WIDTH (1),
      .DEPTH (pst_pkg::MAP_DEPTH)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   assign done  = done_ff;
   assign count = count_ff;

endmodule

### hw/rtl/prime_sieve_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime sieve table core
// Builds a table of primes up to a programmed limit with a sieve engine and
// answers lookups into that table.
//
//   Channel  Ports            Direction  Carries
//   req      req_valid/stall  in         func, entry_index
//   rsp      rsp_valid/stall  out        prime_count, prime_value, entry_valid
//   csr      csr_wr_en/data   in         sieve_limit
//
// A read transaction goes through the registered prime table read, then
// loads the response register.
// A build steps through the clear, sieve and scan states, limited by the
// map RAM and the shared adder.
// Reset is synchronous; the prime count clears to zero and the limit to 20000.
// The request side is stalled while a transaction is in flight; a response
// waiting under stall does not block acceptance of the next request.
// ----------------------------------------------------------------------------
module prime_sieve_table_core (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [pst_pkg::IDX_W-1:0]     req_entry_index,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pst_pkg::CNT_W-1:0]     rsp_prime_count,
   output logic [pst_pkg::VAL_W-1:0]     rsp_prime_value,
   output logic                          rsp_entry_valid,

   input  logic                          csr_wr_en,
   input  logic [pst_pkg::LIM_W-1:0]     csr_wr_data
);

   localparam int CNT_W = pst_pkg::CNT_W;
   localparam int VAL_W = pst_pkg::VAL_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_BUILD,
      ST_BUILD_RSP
   } state_type;

   state_type                    state_ff, state_in;
   logic [pst_pkg::LIM_W-1:0]    limit_ff, limit_in;
   logic [pst_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic                         start_ff, start_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]             rsp_count_ff, rsp_count_in;
   logic [VAL_W-1:0]             rsp_value_ff, rsp_value_in;
   logic                         rsp_hit_ff, rsp_hit_in;

   logic                         req_accept;
   logic                         out_free;
   logic                         hit;
   logic                         tbl_rd_en;
   logic [VAL_W-1:0]             tbl_rd_data;
   logic                         eng_done;
   logic [CNT_W-1:0]             eng_count;
   pst_pkg::tbl_wr_type          tbl_wr;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign hit        = CNT_W'(idx_ff) < eng_count;
   assign tbl_rd_en  = req_accept && (pst_pkg::func_type'(req_func) == pst_pkg::FUNC_READ);

   // Transaction sequencing and response register
   always_comb begin
      state_in     = state_ff;
      limit_in     = limit_ff;
      idx_in       = idx_ff;
      start_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_value_in = rsp_value_ff;
      rsp_hit_in   = rsp_hit_ff;

      // Drop the response once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         limit_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               idx_in = req_entry_index;
               if (pst_pkg::func_type'(req_func) == pst_pkg::FUNC_READ) begin
                  state_in = ST_READ;
               end else begin
                  start_in = 1'b1;
                  state_in = ST_BUILD;
               end
            end
         end
         // Table data is ready; hold until the response register frees up
         ST_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = eng_count;
               rsp_hit_in   = hit;
               rsp_value_in = hit ? tbl_rd_data : '0;
               state_in     = ST_IDLE;
            end
         end
         ST_BUILD: begin
            if (eng_done) begin
               state_in = ST_BUILD_RSP;
            end
         end
         ST_BUILD_RSP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = eng_count;
               rsp_hit_in   = 1'b0;
               rsp_value_in = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= pst_pkg::LIM_RESET;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      rsp_count_ff <= rsp_count_in;
      rsp_value_ff <= rsp_value_in;
      rsp_hit_ff   <= rsp_hit_in;
   end

   pst_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ff),
      .limit  (limit_ff),
      .done   (eng_done),
      .count  (eng_count),
      .tbl_wr (tbl_wr)
   );

   pst_ram #(
      .WIDTH (VAL_W),
      .DEPTH (pst_pkg::TABLE_DEPTH)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (tbl_wr.en),
      .wr_addr (tbl_wr.addr),
      .wr_data (tbl_wr.data),
      .rd_en   (tbl_rd_en),
      .rd_addr (req_entry_index[pst_pkg::TBL_AW-1:0]),
      .rd_data (tbl_rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_count = rsp_count_ff;
   assign rsp_prime_value = rsp_value_ff;
   assign rsp_entry_valid = rsp_hit_ff;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime sieve table core testbench
// Sends build and lookup transactions under several sieve limits, from zero
// up to the full 16-bit range. A scoreboard runs its own sieve on every
// accepted build and predicts each response. Requests idle and responses
// stall at random outside the quiet phase.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int RANDOM_ITEMS = 1400;
   localparam int PHASE_ITEMS  = 100;
   localparam int TAIL_CYCLES  = 8;

   typedef struct {
      logic [pst_pkg::CNT_W-1:0] count;
      logic [pst_pkg::VAL_W-1:0] value;
      logic                      hit;
   } lookup_answer_type;

   // Scoreboard: own sieve, own prime table and the queue of expected responses
   class prime_table_scoreboard_type;
      bit                        composite [pst_pkg::MAP_DEPTH];
      logic [pst_pkg::VAL_W-1:0] primes [pst_pkg::TABLE_DEPTH];
      int unsigned               found;
      logic [pst_pkg::LIM_W-1:0] sieve_limit;
      lookup_answer_type         expected_answers [$];
      int unsigned               errors;
      int unsigned               builds;
      int unsigned               lookups;
      int unsigned               hits;

      function new();
         found       = 0;
         sieve_limit = pst_pkg::LIM_RESET;
         errors      = 0;
         builds      = 0;
         lookups     = 0;
         hits        = 0;
      endfunction

      // Rebuild the prime table up to the current limit
      function void sieve_primes();
         int unsigned lim;
         int unsigned i;
         int unsigned j;
         lim = sieve_limit;
         if (lim > pst_pkg::MAP_DEPTH - 1) lim = pst_pkg::MAP_DEPTH - 1;
         for (i = 0; i <= lim; i++) composite[i] = 1'b0;
         composite[0] = 1'b1;
         composite[1] = 1'b1;
         for (i = 2; i * i <= lim; i++) begin
            if (!composite[i]) begin
               for (j = i * i; j <= lim; j += i) composite[j] = 1'b1;
            end
         end
         found = 0;
         for (i = 2; i <= lim; i++) begin
            if (!composite[i] && found < pst_pkg::TABLE_DEPTH) begin
               primes[found] = pst_pkg::VAL_W'(i);
               found++;
            end
         end
      endfunction

      // Predict the response of one accepted request transaction
      function void note_request(pst_pkg::func_type op, logic [pst_pkg::IDX_W-1:0] idx);
         lookup_answer_type ans;
         if (op == pst_pkg::FUNC_BUILD) begin
            sieve_primes();
            builds++;
            ans.count = pst_pkg::CNT_W'(found);
            ans.value = '0;
            ans.hit   = 1'b0;
         end else begin
            lookups++;
            ans.count = pst_pkg::CNT_W'(found);
            if (idx < found) begin
               ans.value = primes[idx];
               ans.hit   = 1'b1;
               hits++;
            end else begin
               ans.value = '0;
               ans.hit   = 1'b0;
            end
         end
         expected_answers.push_back(ans);
      endfunction

      // Compare one accepted response with the oldest prediction
      function void check_response(logic [pst_pkg::CNT_W-1:0] count,
                                   logic [pst_pkg::VAL_W-1:0] value, logic hit);
         lookup_answer_type ans;
         if (expected_answers.size() == 0) begin
            $display("%0t: unexpected response: count %0d value %0d valid %0b",
                     $time, count, value, hit);
            errors++;
            return;
         end
         ans = expected_answers.pop_front();
         if (count !== ans.count) begin
            $display("%0t: prime_count mismatch: expected %0d, actual %0d",
                     $time, ans.count, count);
            errors++;
         end
         if (value !== ans.value) begin
            $display("%0t: prime_value mismatch: expected %0d, actual %0d",
                     $time, ans.value, value);
            errors++;
         end
         if (hit !== ans.hit) begin
            $display("%0t: entry_valid mismatch: expected %0b, actual %0b",
                     $time, ans.hit, hit);
            errors++;
         end
      endfunction
   endclass

   logic                         clock;
   logic                         reset           = 1'b1;
   logic                         req_valid       = 1'b0;
   logic                         req_stall;
   logic                         req_func        = 1'b0;
   logic [pst_pkg::IDX_W-1:0]    req_entry_index = '0;
   logic                         rsp_valid;
   logic                         rsp_stall       = 1'b0;
   logic [pst_pkg::CNT_W-1:0]    rsp_prime_count;
   logic [pst_pkg::VAL_W-1:0]    rsp_prime_value;
   logic                         rsp_entry_valid;
   logic                         csr_wr_en       = 1'b0;
   logic [pst_pkg::LIM_W-1:0]    csr_wr_data     = '0;

   logic                         quiet           = 1'b0;
   int unsigned                  cycles          = 0;
   int unsigned                  limits_used     = 0;
   prime_table_scoreboard_type   sb;

   prime_sieve_table_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_entry_index (req_entry_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_prime_count (rsp_prime_count),
      .rsp_prime_value (rsp_prime_value),
      .rsp_entry_valid (rsp_entry_valid),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stall the response side now and then, except in the quiet stretch
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 6);
   end

   // Check every response transaction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_prime_count, rsp_prime_value, rsp_entry_valid);
   end

   // Abort a hung run
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Send one request transaction, with an optional random gap before it
   task automatic send_item(input pst_pkg::func_type op,
                            input logic [pst_pkg::IDX_W-1:0] idx);
      while (!quiet && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= op;
      req_entry_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(op, idx);
   endtask

   // Hold off requests until every predicted response has arrived
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_answers.size() != 0) @(posedge clock);
   endtask

   // Program the sieve limit once the core is idle
   task automatic program_limit(input logic [pst_pkg::LIM_W-1:0] limit);
      drain();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.sieve_limit = limit;
      limits_used++;
   endtask

   initial begin
      logic [pst_pkg::LIM_W-1:0] edge_limits [5];
      logic [pst_pkg::LIM_W-1:0] limit;
      int                        sent;
      int                        phase;
      int                        roll;

      sb = new();
      edge_limits = '{pst_pkg::LIM_W'(0), pst_pkg::LIM_W'(1), pst_pkg::LIM_W'(2),
                      pst_pkg::LIM_W'(3), pst_pkg::LIM_W'(65535)};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Lookups before any build, then a build at the reset limit and lookups into it
      send_item(pst_pkg::FUNC_READ, '0);
      send_item(pst_pkg::FUNC_READ, '1);
      send_item(pst_pkg::FUNC_BUILD, '0);
      send_item(pst_pkg::FUNC_READ, '0);
      send_item(pst_pkg::FUNC_READ, pst_pkg::IDX_W'(sb.found - 1));
      send_item(pst_pkg::FUNC_READ, pst_pkg::IDX_W'(sb.found));
      send_item(pst_pkg::FUNC_READ, '1);

      // Limits below two, the smallest real ones and the full range
      for (int k = 0; k < 5; k++) begin
         program_limit(edge_limits[k]);
         send_item(pst_pkg::FUNC_BUILD, '1);
         send_item(pst_pkg::FUNC_READ, '0);
         if (sb.found > 0) send_item(pst_pkg::FUNC_READ, pst_pkg::IDX_W'(sb.found - 1));
         send_item(pst_pkg::FUNC_READ, pst_pkg::IDX_W'(sb.found));
      end

      // Random phases: build first, then mostly lookups with a few rebuilds
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         if (phase == 3)
            limit = pst_pkg::LIM_W'($urandom_range(400, 3000));
         else if ($urandom_range(9) == 0)
            limit = pst_pkg::LIM_W'($urandom_range(0, 1));
         else
            limit = pst_pkg::LIM_W'($urandom_range(2, 400));
         program_limit(limit);
         quiet <= (phase == 5);
         send_item(pst_pkg::FUNC_BUILD, pst_pkg::IDX_W'($urandom));
         for (int n = 1; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(99);
            if (roll < 4)
               send_item(pst_pkg::FUNC_BUILD, pst_pkg::IDX_W'($urandom));
            else if (roll < 74)
               send_item(pst_pkg::FUNC_READ,
                         pst_pkg::IDX_W'($urandom_range(0, sb.found + 1)));
            else
               send_item(pst_pkg::FUNC_READ,
                         pst_pkg::IDX_W'($urandom_range(0, (1 << pst_pkg::IDX_W) - 1)));
         end
         sent += PHASE_ITEMS;
         phase++;
      end

      // Let the last responses land, then report
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.expected_answers.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, sb.expected_answers.size());
         sb.errors++;
      end
      $display("Ran %0d builds and %0d lookups (%0d inside the table)",
               sb.builds, sb.lookups, sb.hits);
      $display("Limit was reprogrammed %0d times, from 0 up to 65535", limits_used);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### prime_sieve_table_core.f
hw/rtl/pst_pkg.sv
hw/rtl/pst_ram.sv
hw/rtl/pst_engine.sv
hw/rtl/prime_sieve_table_core.sv
tb/tb_top.sv
